>>> design/lsd_pkg.sv
// ----------------------------------------------------------------------------
// lsd_pkg: shared types and constants of the stillness / landing detector
// Field widths, register indexes, command codes and reset values.
// ----------------------------------------------------------------------------
package lsd_pkg;

   // field widths
   localparam int SAMPLE_W    = 10;
   localparam int OUT_W       = 17;
   localparam int CNT_W       = 16;
   localparam int BAND_W      = 10;

   // configuration port
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_STILL_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STILL_BAND  = 1'b1;

   // request command codes, also used as job kinds
   localparam logic CMD_CALIB   = 1'b0;
   localparam logic CMD_MEASURE = 1'b1;

   // reset values
   localparam logic [CNT_W-1:0]  STILL_COUNT_RESET = 16'd10;
   localparam logic [BAND_W-1:0] STILL_BAND_RESET  = 10'd5;
   localparam int                REF_RESET_COUNTS  = 1000;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [CNT_W-1:0]  still_count;
      logic [BAND_W-1:0] still_band;
   } csr_regs_type;

endpackage

>>> design/lsd_req_if.sv
// ----------------------------------------------------------------------------
// lsd_req_if: request channel of the stillness / landing detector
// One three-axis ADC sample and its command per request.
// ----------------------------------------------------------------------------
interface lsd_req_if;
   import lsd_pkg::*;

   logic                valid;
   logic                ready;
   logic                command;
   logic [SAMPLE_W-1:0] sample_x;
   logic [SAMPLE_W-1:0] sample_y;
   logic [SAMPLE_W-1:0] sample_z;

   modport source (output valid, command, sample_x, sample_y, sample_z, input ready);
   modport sink   (input valid, command, sample_x, sample_y, sample_z, output ready);

endinterface

>>> design/lsd_rsp_if.sv
// ----------------------------------------------------------------------------
// lsd_rsp_if: result channel of the stillness / landing detector
// Offset-corrected window means, countdown and landed flag.
// ----------------------------------------------------------------------------
interface lsd_rsp_if;
   import lsd_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] accel_x;
   logic signed [OUT_W-1:0] accel_y;
   logic signed [OUT_W-1:0] accel_z;
   logic signed [OUT_W-1:0] still_left;
   logic                    landed;

   modport source (output valid, accel_x, accel_y, accel_z, still_left, landed, input ready);
   modport sink   (input valid, accel_x, accel_y, accel_z, still_left, landed, output ready);

endinterface

>>> design/lsd_front.sv
// ----------------------------------------------------------------------------
// lsd_front: request intake and window accumulation
// Sorts samples into calibration or measurement windows and pushes one job
// with the three axis sums when a window closes.
// ----------------------------------------------------------------------------
module lsd_front #(
   parameter int CAL_SAMPLES = 100,
   parameter int AVG_SAMPLES = 25,
   parameter int SUM_W       = 17
) (
   input  logic                  clock,
   input  logic                  reset,
   lsd_req_if.sink               req_ch,
   input  logic                  queue_full,
   output logic                  job_push,
   output logic                  job_kind,
   output logic [2:0][SUM_W-1:0] job_sums
);
   import lsd_pkg::*;

   localparam int CCNT_W = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;
   localparam int WCNT_W = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
   localparam int CSUM_W = SAMPLE_W + $clog2(CAL_SAMPLES);
   localparam int WSUM_W = SAMPLE_W + $clog2(AVG_SAMPLES);

   logic                     accept;
   logic [2:0][SAMPLE_W-1:0] sample;
   logic                     cal_end;
   logic                     win_end;
   logic [CCNT_W-1:0]        cal_cnt_ff, cal_cnt_in;
   logic [WCNT_W-1:0]        win_cnt_ff, win_cnt_in;
   logic [2:0][CSUM_W-1:0]   cal_sum_ff, cal_sum_in, cal_add;
   logic [2:0][WSUM_W-1:0]   win_sum_ff, win_sum_in, win_add;

   // take a request whenever the queue has room for its job
   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign sample       = {req_ch.sample_z, req_ch.sample_y, req_ch.sample_x};

   assign cal_end = (cal_cnt_ff == CCNT_W'(CAL_SAMPLES - 1));
   assign win_end = (win_cnt_ff == WCNT_W'(AVG_SAMPLES - 1));

   // add the new sample to both running sums
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         cal_add[a] = cal_sum_ff[a] + CSUM_W'(sample[a]);
         win_add[a] = win_sum_ff[a] + WSUM_W'(sample[a]);
      end
   end

   // advance the window of the request's kind; close it on its last sample
   always_comb begin
      cal_cnt_in = cal_cnt_ff;
      cal_sum_in = cal_sum_ff;
      win_cnt_in = win_cnt_ff;
      win_sum_in = win_sum_ff;
      job_push   = 1'b0;
      job_kind   = req_ch.command;
      for (int a = 0; a < 3; a++) begin
         job_sums[a] = (req_ch.command == CMD_CALIB) ? SUM_W'(cal_add[a])
                                                     : SUM_W'(win_add[a]);
      end
      if (accept) begin
         if (req_ch.command == CMD_CALIB) begin
            if (cal_end) begin
               cal_cnt_in = '0;
               cal_sum_in = '0;
               job_push   = 1'b1;
            end else begin
               cal_cnt_in = cal_cnt_ff + CCNT_W'(1);
               cal_sum_in = cal_add;
            end
         end else begin
            if (win_end) begin
               win_cnt_in = '0;
               win_sum_in = '0;
               job_push   = 1'b1;
            end else begin
               win_cnt_in = win_cnt_ff + WCNT_W'(1);
               win_sum_in = win_add;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_cnt_ff <= '0;
         cal_sum_ff <= '0;
         win_cnt_ff <= '0;
         win_sum_ff <= '0;
      end else begin
         cal_cnt_ff <= cal_cnt_in;
         cal_sum_ff <= cal_sum_in;
         win_cnt_ff <= win_cnt_in;
         win_sum_ff <= win_sum_in;
      end
   end

endmodule

>>> design/lsd_queue.sv
// ----------------------------------------------------------------------------
// lsd_queue: short job queue between front and back
// Register-based FIFO; lets intake and arithmetic stall independently.
// ----------------------------------------------------------------------------
module lsd_queue #(
   parameter int DATA_W = 52
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   output logic              valid,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data
);
   import lsd_pkg::*;

   logic [DATA_W-1:0] mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("job pushed into a full queue");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> valid)
      else $error("job popped from an empty queue");

   a_empty_ptrs : assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");

endmodule

>>> design/lsd_mean_div.sv
// ----------------------------------------------------------------------------
// lsd_mean_div: three-stage rounded mean by a constant divisor
// Computes (sum * 2^FRAC_BITS + DIVISOR/2) / DIVISOR as an integer quotient
// plus a rounded fraction, each by an exact reciprocal multiply.
// ----------------------------------------------------------------------------
module lsd_mean_div #(
   parameter int DIVISOR   = 25,
   parameter int SUM_W     = 17,
   parameter int FRAC_BITS = 6
) (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic [SUM_W-1:0]                     sum_in,
   output logic [lsd_pkg::SAMPLE_W+FRAC_BITS:0] mean_out
);
   import lsd_pkg::*;

   // floor(x * M >> (K + L)) == floor(x / DIVISOR) for every x below 2^K
   localparam int L    = $clog2(DIVISOR);
   localparam int K1   = SUM_W;
   localparam int P1_W = 2 * K1 + 1;
   localparam longint unsigned M1 =
      ((64'd1 << (K1 + L)) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam int Q1_W = SAMPLE_W;
   localparam int RW   = (L > 0) ? L : 1;
   localparam int K2   = RW + FRAC_BITS + 1;
   localparam int P2_W = 2 * K2 + 1;
   localparam longint unsigned M2 =
      ((64'd1 << (K2 + L)) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam int HALF   = DIVISOR / 2;
   localparam int Q2_W   = FRAC_BITS + 1;
   localparam int MEAN_W = SAMPLE_W + FRAC_BITS + 1;

   logic [P1_W-1:0]  p1;
   logic [Q1_W-1:0]  q1_in;
   logic [Q1_W-1:0]  q1a_ff, q1b_ff, q1c_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] rem_full;
   logic [K2-1:0]    x2_in, x2_ff;
   logic [P2_W-1:0]  p2;
   logic [Q2_W-1:0]  q2_in, q2_ff;

   // stage 1: integer part of the mean
   assign p1    = P1_W'(sum_in) * P1_W'(M1);
   assign q1_in = p1[K1 + L +: Q1_W];

   // stage 2: remainder, scaled and biased for round-half-up
   assign rem_full = sum_ff - SUM_W'(32'(q1a_ff) * 32'(DIVISOR));
   assign x2_in    = (K2'(rem_full[RW-1:0]) << FRAC_BITS) + K2'(HALF);

   // stage 3: fraction bits of the mean
   assign p2    = P2_W'(x2_ff) * P2_W'(M2);
   assign q2_in = p2[K2 + L +: Q2_W];

   assign mean_out = (MEAN_W'(q1c_ff) << FRAC_BITS) + MEAN_W'(q2_ff);

   // advance all stages together
   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= sum_in;
         q1a_ff <= q1_in;
         q1b_ff <= q1a_ff;
         x2_ff  <= x2_in;
         q1c_ff <= q1b_ff;
         q2_ff  <= q2_in;
      end
   end

endmodule

>>> design/lsd_back.sv
// ----------------------------------------------------------------------------
// lsd_back: job execution and stillness detection
// Divides the window sums, loads offsets from calibration jobs, corrects
// measurement means, runs the stillness countdown and holds the result.
// ----------------------------------------------------------------------------
module lsd_back #(
   parameter int CAL_SAMPLES = 100,
   parameter int AVG_SAMPLES = 25,
   parameter int FRAC_BITS   = 6,
   parameter int SUM_W       = 17
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   input  logic                  job_kind,
   input  logic [2:0][SUM_W-1:0] job_sums,
   output logic                  job_pop,
   input  lsd_pkg::csr_regs_type csr,
   lsd_rsp_if.source             rsp_ch
);
   import lsd_pkg::*;

   localparam int MEAN_W = SAMPLE_W + FRAC_BITS + 1;
   localparam int ACC_W  = MEAN_W + 1;
   localparam int D_W    = ACC_W + 1;

   logic                     adv;
   logic [2:0]               vld_ff, vld_in;
   logic [2:0]               kind_ff, kind_in;
   logic [2:0][MEAN_W-1:0]   cal_mean;
   logic [2:0][MEAN_W-1:0]   meas_mean;
   logic [MEAN_W-1:0]        offset_ff [3];
   logic signed [ACC_W-1:0]  acc_in [3];
   logic signed [ACC_W-1:0]  acc_ff [3];
   logic                     acc_vld_ff, acc_vld_in;
   logic signed [ACC_W-1:0]  reference_ff [3];
   logic signed [OUT_W-1:0]  still_cd_ff;
   logic signed [OUT_W-1:0]  cd_next;
   logic signed [D_W-1:0]    band_s;
   logic signed [D_W-1:0]    dev [3];
   logic                     is_still;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]  accel_ff [3];
   logic signed [OUT_W-1:0]  still_left_ff;
   logic                     landed_ff;

   // whole pipeline moves unless a finished result is stuck
   assign adv     = !rsp_valid_ff || rsp_ch.ready;
   assign job_pop = job_valid && adv;
   assign vld_in  = {vld_ff[1:0], job_pop};
   assign kind_in = {kind_ff[1:0], job_kind};

   // one divider pair per axis, both fed every job
   for (genvar a = 0; a < 3; a++) begin : g_axis
      lsd_mean_div #(
         .DIVISOR   (CAL_SAMPLES),
         .SUM_W     (SUM_W),
         .FRAC_BITS (FRAC_BITS)
      ) u_cal_div (
         .clock    (clock),
         .en       (adv),
         .sum_in   (job_sums[a]),
         .mean_out (cal_mean[a])
      );

      lsd_mean_div #(
         .DIVISOR   (AVG_SAMPLES),
         .SUM_W     (SUM_W),
         .FRAC_BITS (FRAC_BITS)
      ) u_meas_div (
         .clock    (clock),
         .en       (adv),
         .sum_in   (job_sums[a]),
         .mean_out (meas_mean[a])
      );
   end

   // correct measurement means with the offsets in force at this point
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         acc_in[a] = $signed(ACC_W'(meas_mean[a])) - $signed(ACC_W'(offset_ff[a]));
      end
   end
   assign acc_vld_in = vld_ff[2] && (kind_ff[2] == CMD_MEASURE);

   // compare against the reference inside the strict band
   assign band_s = $signed(D_W'(csr.still_band) << FRAC_BITS);
   always_comb begin
      is_still = 1'b1;
      for (int a = 0; a < 3; a++) begin
         dev[a] = D_W'(reference_ff[a]) - D_W'(acc_ff[a]);
         if (!((dev[a] > -band_s) && (dev[a] < band_s))) begin
            is_still = 1'b0;
         end
      end
   end

   // count down while still, stop at minus one; reload on movement
   always_comb begin
      if (is_still) begin
         cd_next = still_cd_ff[OUT_W-1] ? still_cd_ff : still_cd_ff - OUT_W'(1);
      end else begin
         cd_next = $signed({1'b0, csr.still_count});
      end
   end

   // hold the result until taken, load the next one behind it
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (adv && acc_vld_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control state and stored detector state
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         acc_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         still_cd_ff  <= $signed({1'b0, STILL_COUNT_RESET});
         for (int a = 0; a < 3; a++) begin
            offset_ff[a]    <= '0;
            reference_ff[a] <= $signed(ACC_W'(REF_RESET_COUNTS) << FRAC_BITS);
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (adv) begin
            vld_ff     <= vld_in;
            acc_vld_ff <= acc_vld_in;
            if (vld_ff[2] && (kind_ff[2] == CMD_CALIB)) begin
               for (int a = 0; a < 3; a++) begin
                  offset_ff[a] <= cal_mean[a];
               end
            end
            if (acc_vld_ff) begin
               still_cd_ff <= cd_next;
               if (!is_still) begin
                  for (int a = 0; a < 3; a++) begin
                     reference_ff[a] <= acc_ff[a];
                  end
               end
            end
         end
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (adv) begin
         kind_ff <= kind_in;
         for (int a = 0; a < 3; a++) begin
            acc_ff[a] <= acc_in[a];
         end
         if (acc_vld_ff) begin
            for (int a = 0; a < 3; a++) begin
               accel_ff[a] <= OUT_W'(acc_ff[a]);
            end
            still_left_ff <= cd_next;
            landed_ff     <= cd_next[OUT_W-1];
         end
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.accel_x    = accel_ff[0];
   assign rsp_ch.accel_y    = accel_ff[1];
   assign rsp_ch.accel_z    = accel_ff[2];
   assign rsp_ch.still_left = still_left_ff;
   assign rsp_ch.landed     = landed_ff;

   a_stall_freezes : assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(vld_ff) && $stable(acc_vld_ff)))
      else $error("pipeline moved while the result was stalled");

   a_cd_floor : assert property (@(posedge clock) disable iff (reset)
      !still_cd_ff[OUT_W-1] || (still_cd_ff == {OUT_W{1'b1}}))
      else $error("countdown fell below minus one");

   a_landed_sign : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (landed_ff == still_left_ff[OUT_W-1]))
      else $error("landed flag disagrees with countdown sign");

   a_result_loaded : assert property (@(posedge clock) disable iff (reset)
      (adv && acc_vld_ff) |=> rsp_valid_ff)
      else $error("finished measurement did not reach the output register");

endmodule

>>> design/accel_stillness_landing_detector_core.sv
// ----------------------------------------------------------------------------
// accel_stillness_landing_detector_core: accelerometer landing detector
// Calibrates per-axis offsets, averages measurement windows and declares
// landing after a run of still windows.
//
//   channel  direction  handshake        payload
//   req_ch   in         valid / ready    command, sample_x/y/z (10 bit)
//   rsp_ch   out        valid / ready    accel_x/y/z, still_left (17 bit s), landed
//   csr_*    in         csr_we           csr_index, csr_wdata (16 bit)
//
// One request is taken per cycle; req_ch.ready drops only when the four-entry
// job queue is full.
// After the request that closes its window, a result passes through the queue,
// three divider stages, offset correction and the output register.
// A result waiting in the output register holds the whole back end; the queue
// then absorbs up to four window closures before req_ch.ready drops.
// Reset is synchronous and active high; it clears control and detector state, not payload.
// ----------------------------------------------------------------------------
module accel_stillness_landing_detector_core #(
   parameter int CAL_SAMPLES = 100,
   parameter int AVG_SAMPLES = 25,
   parameter int FRAC_BITS   = 6
) (
   input  logic                            clock,
   input  logic                            reset,
   lsd_req_if.sink                         req_ch,
   lsd_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [lsd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lsd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lsd_pkg::*;

   localparam int MAX_WIN = (CAL_SAMPLES > AVG_SAMPLES) ? CAL_SAMPLES : AVG_SAMPLES;
   localparam int SUM_W   = SAMPLE_W + $clog2(MAX_WIN);
   localparam int QD_W    = 1 + 3 * SUM_W;

   csr_regs_type          csr_ff, csr_in;
   logic                  job_push;
   logic                  job_kind;
   logic [2:0][SUM_W-1:0] job_sums;
   logic                  queue_full;
   logic                  queue_valid;
   logic                  queue_pop;
   logic [QD_W-1:0]       queue_data;
   logic                  q_kind;
   logic [2:0][SUM_W-1:0] q_sums;

   // decode register writes
   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_STILL_COUNT: csr_in.still_count = csr_wdata[CNT_W-1:0];
            CSR_STILL_BAND:  csr_in.still_band  = csr_wdata[BAND_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.still_count <= STILL_COUNT_RESET;
         csr_ff.still_band  <= STILL_BAND_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   lsd_front #(
      .CAL_SAMPLES (CAL_SAMPLES),
      .AVG_SAMPLES (AVG_SAMPLES),
      .SUM_W       (SUM_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .job_push   (job_push),
      .job_kind   (job_kind),
      .job_sums   (job_sums)
   );

   lsd_queue #(
      .DATA_W (QD_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data ({job_kind, job_sums}),
      .full      (queue_full),
      .valid     (queue_valid),
      .pop       (queue_pop),
      .pop_data  (queue_data)
   );

   // split the queued job
   assign q_kind = queue_data[QD_W-1];
   assign q_sums = queue_data[QD_W-2:0];

   lsd_back #(
      .CAL_SAMPLES (CAL_SAMPLES),
      .AVG_SAMPLES (AVG_SAMPLES),
      .FRAC_BITS   (FRAC_BITS),
      .SUM_W       (SUM_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (queue_valid),
      .job_kind  (q_kind),
      .job_sums  (q_sums),
      .job_pop   (queue_pop),
      .csr       (csr_ff),
      .rsp_ch    (rsp_ch)
   );

endmodule

>>> tb/sv/accel_stillness_landing_detector_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// accel_stillness_landing_detector_core_tb: self-checking bench of the detector
// Drives calibration and measurement requests with random idling and a long
// result hold-off. A scoreboard class computes the expected window results
// and checks each accepted result field by field in order.
// ----------------------------------------------------------------------------
module accel_stillness_landing_detector_core_tb;
   import lsd_pkg::*;

   localparam int CAL_N        = 100;
   localparam int AVG_N        = 25;
   localparam int FRAC         = 6;
   localparam int ITEM_TARGET  = 1350;
   localparam int IDLE_PCT     = 37;
   localparam int HOLD_CYCLES  = 500;
   localparam int DRAIN_CYCLES = 12;

   typedef struct {
      logic signed [OUT_W-1:0] accel_x;
      logic signed [OUT_W-1:0] accel_y;
      logic signed [OUT_W-1:0] accel_z;
      logic signed [OUT_W-1:0] still_left;
      logic                    landed;
   } window_result_type;

   // Tracks detector state and holds the window results still to come
   class landing_checker;
      logic [CNT_W-1:0]    reload_count;
      logic [BAND_W-1:0]   band_counts;
      logic [16:0]         cal_sum[3];
      logic [6:0]          cal_fill;
      logic [15:0]         offset[3];
      logic [14:0]         win_sum[3];
      logic [4:0]          win_fill;
      logic signed [17:0]  ref_level[3];
      logic signed [16:0]  countdown;
      window_result_type   results_due[$];
      int                  errors;
      int                  results;
      int                  still_windows;
      int                  landings;
      int                  calibrations;

      function new();
         reload_count = STILL_COUNT_RESET;
         band_counts  = STILL_BAND_RESET;
         for (int a = 0; a < 3; a++) begin
            cal_sum[a]   = '0;
            offset[a]    = '0;
            win_sum[a]   = '0;
            ref_level[a] = 18'(REF_RESET_COUNTS << FRAC);
         end
         cal_fill  = '0;
         win_fill  = '0;
         countdown = $signed({1'b0, STILL_COUNT_RESET});
      endfunction

      // rounded mean with FRAC fraction bits, halves up
      function int unsigned fixed_mean(int unsigned total, int unsigned n);
         return ((total << FRAC) + n / 2) / n;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_STILL_COUNT: reload_count = data[CNT_W-1:0];
            CSR_STILL_BAND:  band_counts  = data[BAND_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return results_due.size();
      endfunction

      // Advance state by one accepted request; queue a result at window end
      function void take_sample(logic cmd, logic [SAMPLE_W-1:0] x, logic [SAMPLE_W-1:0] y,
                                logic [SAMPLE_W-1:0] z);
         logic [SAMPLE_W-1:0] smp[3];
         int                  acc[3];
         int                  band;
         int                  diff;
         bit                  still;
         window_result_type   r;
         smp[0] = x;
         smp[1] = y;
         smp[2] = z;
         if (cmd == CMD_CALIB) begin
            for (int a = 0; a < 3; a++) cal_sum[a] += 17'(smp[a]);
            cal_fill++;
            if (cal_fill >= 7'(CAL_N)) begin
               for (int a = 0; a < 3; a++) begin
                  offset[a]  = 16'(fixed_mean(32'(cal_sum[a]), CAL_N));
                  cal_sum[a] = '0;
               end
               cal_fill = '0;
               calibrations++;
            end
            return;
         end
         for (int a = 0; a < 3; a++) win_sum[a] += 15'(smp[a]);
         win_fill++;
         if (win_fill < 5'(AVG_N)) return;

         for (int a = 0; a < 3; a++) begin
            acc[a]     = int'(fixed_mean(32'(win_sum[a]), AVG_N)) - int'(offset[a]);
            win_sum[a] = '0;
         end
         win_fill = '0;

         // still only if every axis is strictly inside the band
         band  = int'(band_counts) << FRAC;
         still = 1'b1;
         for (int a = 0; a < 3; a++) begin
            diff = int'(ref_level[a]) - acc[a];
            if (!(diff > -band && diff < band)) still = 1'b0;
         end
         if (still) begin
            still_windows++;
            if (countdown > -17'sd1) countdown--;
         end else begin
            for (int a = 0; a < 3; a++) ref_level[a] = 18'(acc[a]);
            countdown = $signed({1'b0, reload_count});
         end

         r.accel_x    = acc[0][OUT_W-1:0];
         r.accel_y    = acc[1][OUT_W-1:0];
         r.accel_z    = acc[2][OUT_W-1:0];
         r.still_left = countdown;
         r.landed     = (countdown < 17'sd0);
         results_due.push_back(r);
      endfunction

      function void check_field(string name, int want, int got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      // Compare one accepted result with the oldest one due
      function void check_window_result(window_result_type got);
         window_result_type want;
         if (results_due.size() == 0) begin
            $error("result with none due: accel %0d %0d %0d", got.accel_x, got.accel_y,
                   got.accel_z);
            errors++;
            return;
         end
         want = results_due.pop_front();
         check_field("accel_x", int'(want.accel_x), int'(got.accel_x));
         check_field("accel_y", int'(want.accel_y), int'(got.accel_y));
         check_field("accel_z", int'(want.accel_z), int'(got.accel_z));
         check_field("still_left", int'(want.still_left), int'(got.still_left));
         check_field("landed", int'(want.landed), int'(got.landed));
         results++;
         if (want.landed) landings++;
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lsd_req_if req_ch ();
   lsd_rsp_if rsp_ch ();

   landing_checker sb;
   bit             req_idle_en;
   bit             rsp_idle_en;
   int             hold_starts;
   int             requests_sent;
   int             reg_writes;
   int             axis_base[3];

   accel_stillness_landing_detector_core #(
      .CAL_SAMPLES(CAL_N),
      .AVG_SAMPLES(AVG_N),
      .FRAC_BITS  (FRAC)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // 12 ns clock
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Hard stop if the run hangs
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Drive result ready: hold-off on request, else random stalls
   initial begin : rsp_ready_drive
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_starts != hold_seen) begin
            hold_seen = hold_starts;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (rsp_idle_en && $urandom_range(99) < IDLE_PCT) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Check every accepted result
   always @(posedge clock) begin : rsp_watch
      window_result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.accel_x    = rsp_ch.accel_x;
         got.accel_y    = rsp_ch.accel_y;
         got.accel_z    = rsp_ch.accel_z;
         got.still_left = rsp_ch.still_left;
         got.landed     = rsp_ch.landed;
         sb.check_window_result(got);
      end
   end

   function automatic logic [SAMPLE_W-1:0] near_base(int base, int jitter);
      int v;
      v = base + int'($urandom_range(2 * jitter)) - jitter;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return v[SAMPLE_W-1:0];
   endfunction

   // Offer one request, with random idle first; return at the next falling edge
   task automatic push_request(input logic cmd, input logic [SAMPLE_W-1:0] x,
                               input logic [SAMPLE_W-1:0] y, input logic [SAMPLE_W-1:0] z);
      while (req_idle_en && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.command  <= cmd;
      req_ch.sample_x <= x;
      req_ch.sample_y <= y;
      req_ch.sample_z <= z;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.take_sample(cmd, x, y, z);
      requests_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every result due has come, plus pipeline slack
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.write_reg(idx, data);
      reg_writes++;
      @(negedge clock);
   endtask

   // Close n measurement windows around the axis bases; optional calibration noise
   task automatic run_windows(input int n_win, input int jitter, input int jump_pct,
                              input int calib_pct);
      int closed;
      closed = 0;
      while (closed < n_win) begin
         if (sb.win_fill == 0 && $urandom_range(99) < jump_pct)
            for (int a = 0; a < 3; a++) axis_base[a] = $urandom_range(1023);
         if ($urandom_range(99) < calib_pct) begin
            push_request(CMD_CALIB, 10'($urandom_range(1023)), 10'($urandom_range(1023)),
                         10'($urandom_range(1023)));
         end else if (jitter > 0 && $urandom_range(99) < 2) begin
            push_request(CMD_MEASURE, 10'($urandom_range(1023)), 10'($urandom_range(1023)),
                         10'($urandom_range(1023)));
            if (sb.win_fill == 0) closed++;
         end else begin
            push_request(CMD_MEASURE, near_base(axis_base[0], jitter),
                         near_base(axis_base[1], jitter), near_base(axis_base[2], jitter));
            if (sb.win_fill == 0) closed++;
         end
      end
   endtask

   // Feed calibration samples, with optional measurement samples between, until a calibration window closes
   task automatic finish_calibration(input int jitter, input int meas_pct);
      bit took_cal;
      took_cal = 1'b0;
      while (!(took_cal && sb.cal_fill == 0)) begin
         if ($urandom_range(99) < meas_pct) begin
            push_request(CMD_MEASURE, near_base(axis_base[0], jitter),
                         near_base(axis_base[1], jitter), near_base(axis_base[2], jitter));
         end else begin
            push_request(CMD_CALIB, near_base(axis_base[0], jitter),
                         near_base(axis_base[1], jitter), near_base(axis_base[2], jitter));
            took_cal = 1'b1;
         end
      end
   endtask

   initial begin
      logic [CNT_W-1:0]  new_count;
      logic [BAND_W-1:0] new_band;
      sb              = new();
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_ch.valid    = 1'b0;
      req_ch.command  = CMD_CALIB;
      req_ch.sample_x = '0;
      req_ch.sample_y = '0;
      req_ch.sample_z = '0;
      req_idle_en     = 1'b1;
      rsp_idle_en     = 1'b1;
      hold_starts     = 0;
      requests_sent   = 0;
      reg_writes      = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: field extremes, bit patterns, interleaved commands, no offsets yet
      push_request(CMD_CALIB,   10'd0,    10'd0,    10'd0);
      push_request(CMD_MEASURE, 10'd1023, 10'd1023, 10'd1023);
      push_request(CMD_CALIB,   10'd1023, 10'd1023, 10'd1023);
      push_request(CMD_MEASURE, 10'd0,    10'd0,    10'd0);
      push_request(CMD_MEASURE, 10'h155,  10'h2AA,  10'h155);
      push_request(CMD_CALIB,   10'h2AA,  10'h155,  10'h2AA);
      push_request(CMD_MEASURE, 10'h2AA,  10'h155,  10'h2AA);
      push_request(CMD_CALIB,   10'h155,  10'h2AA,  10'h155);
      push_request(CMD_MEASURE, 10'd1,    10'd512,  10'd1022);
      push_request(CMD_CALIB,   10'd1022, 10'd1,    10'd512);
      push_request(CMD_MEASURE, 10'd512,  10'd1022, 10'd1);
      push_request(CMD_MEASURE, 10'd1023, 10'd0,    10'd1023);

      // Full scale windows with zero offsets, no idling on either side
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      for (int a = 0; a < 3; a++) axis_base[a] = 1023;
      run_windows(3, 0, 0, 0);
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
      wait_drained();

      // Calibrate at full scale, then measure zero: most negative acceleration
      write_reg(CSR_STILL_COUNT, 16'd2);
      write_reg(CSR_STILL_BAND, 16'd8);
      finish_calibration(0, 0);
      finish_calibration(0, 0);
      for (int a = 0; a < 3; a++) axis_base[a] = 0;
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      run_windows(6, 0, 0, 0);
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
      wait_drained();

      // Lowest settings: zero band is never still, zero reload
      write_reg(CSR_STILL_COUNT, 16'd0);
      write_reg(CSR_STILL_BAND, 16'd0);
      run_windows(3, 4, 50, 15);
      wait_drained();

      // Highest settings; junk in the unused band bits
      write_reg(CSR_STILL_COUNT, 16'hFFFF);
      write_reg(CSR_STILL_BAND, {6'($urandom_range(63)), 10'd1023});
      run_windows(3, 8, 30, 10);
      wait_drained();

      // Hold results off while the sender keeps going, so the queue fills
      write_reg(CSR_STILL_COUNT, 16'd1);
      write_reg(CSR_STILL_BAND, 16'd6);
      req_idle_en = 1'b0;
      hold_starts++;
      run_windows(16, 1, 15, 5);
      req_idle_en = 1'b1;
      wait_drained();

      // Random phases: new settings, maybe a calibration, runs of windows
      while (requests_sent < ITEM_TARGET) begin
         if ($urandom_range(1)) begin
            case ($urandom_range(5))
               0: new_count = 16'd0;
               1: new_count = 16'd1;
               2: new_count = 16'd2;
               3: new_count = 16'd3;
               4: new_count = 16'($urandom_range(65535));
               default: new_count = 16'hFFFF;
            endcase
            write_reg(CSR_STILL_COUNT, new_count);
         end
         if ($urandom_range(1)) begin
            case ($urandom_range(4))
               0: new_band = 10'd0;
               1: new_band = 10'($urandom_range(1, 4));
               2: new_band = 10'($urandom_range(5, 12));
               3: new_band = 10'($urandom_range(1023));
               default: new_band = 10'd1023;
            endcase
            write_reg(CSR_STILL_BAND, {6'($urandom_range(63)), new_band});
         end
         if ($urandom_range(99) < 20) begin
            for (int a = 0; a < 3; a++) axis_base[a] = $urandom_range(1023);
            finish_calibration(3, 10);
         end
         run_windows($urandom_range(2, 6), $urandom_range(6), $urandom_range(40),
                     $urandom_range(15));
         wait_drained();
      end

      wait_drained();
      $display("Covered %0d requests, %0d results, %0d still windows, %0d landed results.",
               requests_sent, sb.results, sb.still_windows, sb.landings);
      $display("Completed %0d calibrations across %0d register writes; one %0d-cycle hold-off.",
               sb.calibrations, reg_writes, HOLD_CYCLES);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
